FILE: rtl/core/cvap_pkg.sv
`default_nettype none

package cvap_pkg;

   localparam int ReqWidth = 120;
   localparam int RspWidth = 184;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam int DivWidth = 17;
   localparam int DivisorWidth = 15;

   localparam logic [CsrIndexWidth-1:0] CsrSpatialRank    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBatchCount     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrChannelTotal   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrChannelsInGrp  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrChannelPitch   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrSpanBytes      = 3'd5;

   localparam logic [1:0] StatusOk          = 2'd0;
   localparam logic [1:0] StatusInvalid     = 2'd1;
   localparam logic [1:0] StatusUnsupported = 2'd2;

   localparam logic [1:0] PathGeneric      = 2'd0;
   localparam logic [1:0] PathOneByOne     = 2'd1;
   localparam logic [1:0] PathThreeByThree = 2'd2;

   localparam logic [1:0] ShapeOther = 2'd0;
   localparam logic [1:0] ShapeThree = 2'd2;

   localparam logic [15:0] TapLimit = 16'd16;

   typedef struct packed {
      logic [31:0] pitch_bytes;
      logic [15:0] lead_pad;
      logic [15:0] spread;
      logic [15:0] step;
      logic [7:0]  taps;
      logic [15:0] out_extent;
      logic [15:0] in_extent;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  fill;
      logic [1:0]  kernel_path;
      logic [15:0] tap_points;
      logic [31:0] out_points;
      logic [1:0]  plan_status;
      logic [46:0] tap_step_bytes;
      logic [46:0] out_step_bytes;
      logic [15:0] past_inside;
      logic [15:0] first_inside;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_start;
      logic div_sel;
      logic take_first;
      logic finish;
   } cvap_cmd_type;

   typedef struct packed {
      logic div_busy;
   } cvap_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/conv_address_plan_checker.sv
// Checks one convolution address plan, one spatial axis per request word.
// Each request word describes an axis; axis 0 comes first, then axis 1 when
// the spatial rank register holds 2. Each request gives exactly one response
// word with the interior output range of that axis, the output and kernel
// steps in bytes, and running products of output and kernel sizes. The word
// for the last axis of a plan has tlast set and carries the plan status and
// the kernel path; afterwards the plan state returns to its reset values.
// Configuration registers are written through the csr port; the user must
// write them only while the block is idle, which the block does not enforce.
// A request passes from acceptance through a multiply state, then two
// divisions by the stride that share one restoring divider retiring one
// quotient bit per cycle, and a pack state that loads the result. The
// next request is accepted only after the response is loaded and the
// block is back in idle, so requests are taken one at a time.
// The response sits in an output register, so a new request is
// accepted while the previous response waits; the block holds only when a
// finished result finds the output register still full.
// Reset is synchronous; it loads the register defaults and clears the plan.
`default_nettype none

module conv_address_plan_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // in_extent, out_extent, taps, step, spread, lead_pad, pitch_bytes
   input  wire logic [cvap_pkg::ReqWidth-1:0]         req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // first_inside, past_inside, out_step_bytes, tap_step_bytes, plan_status,
   // out_points, tap_points, kernel_path, zero fill
   output logic [cvap_pkg::RspWidth-1:0]              rsp_tdata,
   // axis_no
   output logic [0:0]                                 rsp_tuser,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_wr_en,
   input  wire logic [cvap_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [cvap_pkg::CsrDataWidth-1:0]     csr_wr_data
);
   import cvap_pkg::*;

   cvap_cmd_type  cmd;
   cvap_stat_type stat;
   rsp_word_type  rsp_view;

   cvap_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   cvap_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   assign rsp_view = rsp_word_type'(rsp_tdata);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in flight");

   a_failed_plan_generic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_view.plan_status != StatusOk) |->
         (rsp_view.kernel_path == PathGeneric))
      else $error("failed plan reports a special kernel path");

   a_mid_plan_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_view.plan_status == StatusOk) && (rsp_view.kernel_path == PathGeneric))
      else $error("status or path reported before the last axis");

   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_view.past_inside >= rsp_view.first_inside))
      else $error("interior range end below its start");

endmodule

`default_nettype wire

FILE: rtl/core/cvap_div.sv
`default_nettype none

module cvap_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [cvap_pkg::DivWidth-1:0]         dividend,
   input  wire logic [cvap_pkg::DivisorWidth-1:0]     divisor,
   output logic                                       busy,
   output logic [cvap_pkg::DivWidth-1:0]              quotient
);
   import cvap_pkg::*;

   logic [4:0]                count_ff, count_in;
   logic [DivisorWidth-1:0]   rem_ff, rem_in;
   logic [DivWidth-1:0]       quot_ff, quot_in;
   logic [DivisorWidth-1:0]   dvs_ff, dvs_in;
   logic [DivisorWidth:0]     shifted;
   logic [DivisorWidth+1:0]   trial;

   assign shifted = {rem_ff, quot_ff[DivWidth-1]};
   assign trial = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      count_in = count_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      dvs_in = dvs_ff;
      if (start) begin
         count_in = 5'(DivWidth);
         rem_in = '0;
         quot_in = dividend;
         dvs_in = divisor;
      end else if (count_ff != 5'd0) begin
         count_in = count_ff - 5'd1;
         if (!trial[DivisorWidth+1]) begin
            rem_in = trial[DivisorWidth-1:0];
            quot_in = {quot_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[DivisorWidth-1:0];
            quot_in = {quot_ff[DivWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      dvs_ff <= dvs_in;
   end

   assign busy = (count_ff != 5'd0);
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cvap_dpath.sv
`default_nettype none

module cvap_dpath (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire cvap_pkg::cvap_cmd_type                   cmd,
   output cvap_pkg::cvap_stat_type                       stat,
   input  wire logic [cvap_pkg::ReqWidth-1:0]            req_tdata,
   input  wire logic                                     csr_wr_en,
   input  wire logic [cvap_pkg::CsrIndexWidth-1:0]       csr_index,
   input  wire logic [cvap_pkg::CsrDataWidth-1:0]        csr_wr_data,
   output logic [cvap_pkg::RspWidth-1:0]                 rsp_tdata,
   output logic [0:0]                                    rsp_tuser,
   output logic                                          rsp_tlast
);
   import cvap_pkg::*;

   logic [1:0]  spatial_rank_ff;
   logic [15:0] batch_count_ff;
   logic [15:0] channel_total_ff;
   logic [15:0] channels_in_group_ff;
   logic [15:0] channel_pitch_ff;
   logic [31:0] span_bytes_ff;

   logic        axis_count_ff, axis_count_in;
   logic [1:0]  sticky_status_ff, sticky_status_in;
   logic [31:0] out_product_ff, out_product_in;
   logic [15:0] tap_product_ff, tap_product_in;
   logic [1:0]  first_axis_shape_ff, first_axis_shape_in;

   req_word_type item_ff;
   logic [46:0]  ostep_ff;
   logic [46:0]  tstep_ff;
   logic [22:0]  tail_ff;
   logic [31:0]  out_next_ff;
   logic [15:0]  tap_next_ff;
   logic [DivWidth-1:0] first_q_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         rsp_axis_ff, rsp_last_ff, rsp_last_in;

   logic [DivisorWidth-1:0] s_val, d_val, p_val;
   logic        step_pos, spread_pos, pad_nonneg, axis_ok;
   logic [46:0] ostep_prod, tstep_prod;
   logic [22:0] tail_prod;
   logic [47:0] out_prod_full;
   logic [23:0] tap_prod_full;
   logic [DivWidth-1:0] div_a, div_b, last_n, div_dividend, div_quot;
   logic [23:0] last_n_wide, span_diff;
   logic        tail_below, div_busy;
   logic [17:0] past_raw, out_ext_wide;
   logic [15:0] first_c, past_c, past_f;
   logic        rank_two, last_axis, cfg_bad, sticky_eff, spread_one;
   logic [1:0]  status_v, path_v;

   assign s_val = item_ff.step[DivisorWidth-1:0];
   assign d_val = item_ff.spread[DivisorWidth-1:0];
   assign p_val = item_ff.lead_pad[DivisorWidth-1:0];
   assign step_pos = !item_ff.step[15] && (item_ff.step != 16'd0);
   assign spread_pos = !item_ff.spread[15] && (item_ff.spread != 16'd0);
   assign pad_nonneg = !item_ff.lead_pad[15];
   assign axis_ok = (item_ff.in_extent != 16'd0) && (item_ff.out_extent != 16'd0) &&
                    (item_ff.taps != 8'd0) && (item_ff.pitch_bytes != 32'd0) &&
                    step_pos && spread_pos && pad_nonneg;

   assign ostep_prod = s_val * item_ff.pitch_bytes;
   assign tstep_prod = d_val * item_ff.pitch_bytes;
   assign tail_prod = (item_ff.taps - 8'd1) * d_val;
   assign out_prod_full = out_product_ff * item_ff.out_extent;
   assign tap_prod_full = tap_product_ff * item_ff.taps;

   assign div_a = {2'b00, p_val} + {2'b00, s_val} - 17'd1;
   assign last_n = {1'b0, item_ff.in_extent} + {2'b00, p_val} - 17'd1;
   assign last_n_wide = {7'd0, last_n};
   assign tail_below = last_n_wide < {1'b0, tail_ff};
   assign span_diff = last_n_wide - {1'b0, tail_ff};
   assign div_b = span_diff[DivWidth-1:0];
   assign div_dividend = cmd.div_sel ? div_b : div_a;

   cvap_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (s_val),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign stat.div_busy = div_busy;

   assign out_ext_wide = {2'b00, item_ff.out_extent};
   assign past_raw = tail_below ? 18'd0 : ({1'b0, div_quot} + 18'd1);
   assign first_c = ({1'b0, first_q_ff} > out_ext_wide) ? item_ff.out_extent
                                                         : first_q_ff[15:0];
   assign past_c = (past_raw > out_ext_wide) ? item_ff.out_extent : past_raw[15:0];
   assign past_f = (past_c < first_c) ? first_c : past_c;

   assign rank_two = (spatial_rank_ff == 2'd2);
   assign last_axis = axis_count_ff || !rank_two;
   assign sticky_eff = (sticky_status_ff != StatusOk) || !axis_ok;
   assign spread_one = (item_ff.spread == 16'd1);
   assign cfg_bad = (span_bytes_ff == 32'd0) || (spatial_rank_ff == 2'd0) ||
                    (spatial_rank_ff == 2'd3) || (batch_count_ff == 16'd0) ||
                    (channel_total_ff == 16'd0) || (channels_in_group_ff == 16'd0) ||
                    (channels_in_group_ff > channel_total_ff);

   always_comb begin
      status_v = StatusOk;
      path_v = PathGeneric;
      if (last_axis) begin
         if (cfg_bad) begin
            status_v = StatusInvalid;
         end else if (channel_pitch_ff != 16'd1) begin
            status_v = StatusUnsupported;
         end else if (sticky_eff) begin
            status_v = StatusInvalid;
         end else if (tap_next_ff > TapLimit) begin
            status_v = StatusUnsupported;
         end
         if (status_v == StatusOk) begin
            if (!rank_two && (item_ff.taps == 8'd1) && spread_one) begin
               path_v = PathOneByOne;
            end else if (rank_two && (first_axis_shape_ff == ShapeThree) &&
                         (item_ff.taps == 8'd3) && spread_one) begin
               path_v = PathThreeByThree;
            end
         end
      end
   end

   always_comb begin
      rsp_word_in = rsp_word_ff;
      rsp_last_in = rsp_last_ff;
      axis_count_in = axis_count_ff;
      sticky_status_in = sticky_status_ff;
      out_product_in = out_product_ff;
      tap_product_in = tap_product_ff;
      first_axis_shape_in = first_axis_shape_ff;
      if (cmd.finish) begin
         rsp_word_in.fill = '0;
         rsp_word_in.kernel_path = path_v;
         rsp_word_in.tap_points = tap_next_ff;
         rsp_word_in.out_points = out_next_ff;
         rsp_word_in.plan_status = status_v;
         rsp_word_in.tap_step_bytes = axis_ok ? tstep_ff : 47'd0;
         rsp_word_in.out_step_bytes = axis_ok ? ostep_ff : 47'd0;
         rsp_word_in.past_inside = axis_ok ? past_f : 16'd0;
         rsp_word_in.first_inside = axis_ok ? first_c : 16'd0;
         rsp_last_in = last_axis;
         if (last_axis) begin
            axis_count_in = 1'b0;
            sticky_status_in = StatusOk;
            out_product_in = 32'd1;
            tap_product_in = 16'd1;
            first_axis_shape_in = ShapeOther;
         end else begin
            axis_count_in = 1'b1;
            sticky_status_in = sticky_eff ? StatusInvalid : StatusOk;
            out_product_in = out_next_ff;
            tap_product_in = tap_next_ff;
            first_axis_shape_in = ((item_ff.taps == 8'd3) && spread_one) ? ShapeThree
                                                                         : ShapeOther;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spatial_rank_ff <= 2'd1;
         batch_count_ff <= 16'd1;
         channel_total_ff <= 16'd1;
         channels_in_group_ff <= 16'd1;
         channel_pitch_ff <= 16'd1;
         span_bytes_ff <= 32'd1;
         axis_count_ff <= 1'b0;
         sticky_status_ff <= StatusOk;
         out_product_ff <= 32'd1;
         tap_product_ff <= 16'd1;
         first_axis_shape_ff <= ShapeOther;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CsrSpatialRank: begin
                  spatial_rank_ff <= csr_wr_data[1:0];
               end
               CsrBatchCount: begin
                  batch_count_ff <= csr_wr_data[15:0];
               end
               CsrChannelTotal: begin
                  channel_total_ff <= csr_wr_data[15:0];
               end
               CsrChannelsInGrp: begin
                  channels_in_group_ff <= csr_wr_data[15:0];
               end
               CsrChannelPitch: begin
                  channel_pitch_ff <= csr_wr_data[15:0];
               end
               CsrSpanBytes: begin
                  span_bytes_ff <= csr_wr_data;
               end
               default: begin
               end
            endcase
         end
         axis_count_ff <= axis_count_in;
         sticky_status_ff <= sticky_status_in;
         out_product_ff <= out_product_in;
         tap_product_ff <= tap_product_in;
         first_axis_shape_ff <= first_axis_shape_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_word_type'(req_tdata);
      end
      if (cmd.mul) begin
         ostep_ff <= ostep_prod;
         tstep_ff <= tstep_prod;
         tail_ff <= tail_prod;
         out_next_ff <= out_prod_full[31:0];
         tap_next_ff <= tap_prod_full[15:0];
      end
      if (cmd.take_first) begin
         first_q_ff <= div_quot;
      end
      if (cmd.finish) begin
         rsp_axis_ff <= axis_count_ff;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tdata = rsp_word_ff;
   assign rsp_tuser = rsp_axis_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cvap_ctrl.sv
`default_nettype none

module cvap_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output cvap_pkg::cvap_cmd_type       cmd,
   input  wire cvap_pkg::cvap_stat_type stat
);
   import cvap_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIVA = 5'b00100,
      ST_DIVB = 5'b01000,
      ST_PACK = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cmd.div_start = 1'b1;
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            if (!stat.div_busy) begin
               cmd.take_first = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel = 1'b1;
               state_in = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (!stat.div_busy) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: tb/conv_address_plan_checker_tb.sv
`default_nettype none

module conv_address_plan_checker_tb;
   import cvap_pkg::*;

   typedef struct packed {
      logic        axis_no;
      logic [15:0] first_inside;
      logic [15:0] past_inside;
      logic [46:0] out_step_bytes;
      logic [46:0] tap_step_bytes;
      logic        plan_done;
      logic [1:0]  plan_status;
      logic [31:0] out_points;
      logic [15:0] tap_points;
      logic [1:0]  kernel_path;
   } plan_result_type;

   typedef enum bit {RowWord, RowReg} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [31:0]     reg_val;
      req_word_type    word;
      bit              typed;
      plan_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [ReqWidth-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RspWidth-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wr_data;

   rsp_word_type rsp_view;
   assign rsp_view = rsp_tdata;

   // Mirror of the registers and of the plan in progress.
   logic [1:0]  cfg_rank;
   logic [15:0] cfg_batch;
   logic [15:0] cfg_total;
   logic [15:0] cfg_group;
   logic [15:0] cfg_pitch;
   logic [31:0] cfg_span;
   logic        axis_count;
   logic        sticky_bad;
   logic [31:0] out_product;
   logic [15:0] tap_product;
   logic [1:0]  first_shape;

   plan_result_type awaited_axes[$];
   stim_row_type dir_tab [40];

   int mismatch_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int setups = 0;
   int plans_ok = 0;
   int plans_invalid = 0;
   int plans_unsupported = 0;
   int paths_one = 0;
   int paths_three = 0;
   bit idle_on = 1'b1;
   int hold_asks = 0;
   int hold_seen = 0;
   int stall_left = 0;

   conv_address_plan_checker DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void forget_plan();
      axis_count = 1'b0;
      sticky_bad = 1'b0;
      out_product = 32'd1;
      tap_product = 16'd1;
      first_shape = ShapeOther;
   endfunction

   function automatic plan_result_type plan_axis(req_word_type w);
      plan_result_type res;
      logic [63:0] s, d, p, tail, lastn, first, past, ext;
      logic last, axis_ok;
      logic [1:0] status, path;
      int rank;
      res = '0;
      rank = (cfg_rank == 2'd2) ? 2 : 1;
      last = axis_count || (rank == 1);
      axis_ok = w.in_extent != 0 && w.out_extent != 0 && w.taps != 0 &&
                w.pitch_bytes != 0 && $signed(w.step) > 0 &&
                $signed(w.spread) > 0 && !w.lead_pad[15];
      if (axis_ok) begin
         s = 64'(w.step);
         d = 64'(w.spread);
         p = 64'(w.lead_pad);
         ext = 64'(w.out_extent);
         tail = (64'(w.taps) - 64'd1) * d;
         lastn = 64'(w.in_extent) - 64'd1 + p;
         first = (p + s - 64'd1) / s;
         past = (lastn < tail) ? 64'd0 : (lastn - tail) / s + 64'd1;
         if (first > ext) first = ext;
         if (past > ext) past = ext;
         if (past < first) past = first;
         res.first_inside = first[15:0];
         res.past_inside = past[15:0];
         res.out_step_bytes = 47'(s * 64'(w.pitch_bytes));
         res.tap_step_bytes = 47'(d * 64'(w.pitch_bytes));
      end else begin
         sticky_bad = 1'b1;
      end
      out_product = out_product * 32'(w.out_extent);
      tap_product = tap_product * 16'(w.taps);
      if (last) begin
         if (cfg_span == 0 || cfg_rank == 2'd0 || cfg_rank == 2'd3 || cfg_batch == 0 ||
             cfg_total == 0 || cfg_group == 0 || cfg_group > cfg_total)
            status = StatusInvalid;
         else if (cfg_pitch != 16'd1)
            status = StatusUnsupported;
         else if (sticky_bad)
            status = StatusInvalid;
         else if (tap_product > TapLimit)
            status = StatusUnsupported;
         else
            status = StatusOk;
         path = PathGeneric;
         if (status == StatusOk) begin
            if (rank == 1 && w.taps == 8'd1 && w.spread == 16'd1)
               path = PathOneByOne;
            else if (rank == 2 && first_shape == ShapeThree && w.taps == 8'd3 &&
                     w.spread == 16'd1)
               path = PathThreeByThree;
         end
         case (status)
            StatusOk: plans_ok++;
            StatusInvalid: plans_invalid++;
            default: plans_unsupported++;
         endcase
         if (path == PathOneByOne) paths_one++;
         if (path == PathThreeByThree) paths_three++;
         res.plan_done = 1'b1;
         res.plan_status = status;
         res.kernel_path = path;
      end else begin
         first_shape = (w.taps == 8'd3 && w.spread == 16'd1) ? ShapeThree : ShapeOther;
      end
      res.axis_no = axis_count;
      res.out_points = out_product;
      res.tap_points = tap_product;
      if (last) forget_plan();
      else axis_count = 1'b1;
      return res;
   endfunction

   function automatic stim_row_type word_row(logic [15:0] in_ext, logic [15:0] out_ext,
                                             logic [7:0] taps, logic [15:0] step,
                                             logic [15:0] spread, logic [15:0] pad,
                                             logic [31:0] pitch);
      stim_row_type r;
      r.kind = RowWord;
      r.reg_idx = '0;
      r.reg_val = '0;
      r.word.in_extent = in_ext;
      r.word.out_extent = out_ext;
      r.word.taps = taps;
      r.word.step = step;
      r.word.spread = spread;
      r.word.lead_pad = pad;
      r.word.pitch_bytes = pitch;
      r.typed = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic stim_row_type reg_row(logic [2:0] idx, logic [31:0] val);
      stim_row_type r;
      r = word_row(16'd0, 16'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
      r.kind = RowReg;
      r.reg_idx = idx;
      r.reg_val = val;
      return r;
   endfunction

   function automatic stim_row_type fixed_row(stim_row_type r, plan_result_type want);
      r.typed = 1'b1;
      r.want = want;
      return r;
   endfunction

   // Single-axis plan whose axis is rejected: only the products survive.
   function automatic plan_result_type bad_axis(logic [31:0] opts, logic [15:0] tpts);
      plan_result_type res;
      res = '0;
      res.plan_done = 1'b1;
      res.plan_status = StatusInvalid;
      res.out_points = opts;
      res.tap_points = tpts;
      res.kernel_path = PathGeneric;
      return res;
   endfunction

   // The plain 8-wide, 1-tap axis with 4-byte pitch.
   function automatic plan_result_type unit_axis(logic [1:0] status, logic [1:0] path);
      return '{1'b0, 16'd0, 16'd8, 47'd4, 47'd4, 1'b1, status, 32'd8, 16'd1, path};
   endfunction

   function automatic req_word_type random_axis();
      req_word_type w;
      int roll;
      roll = $urandom_range(0, 99);
      w.in_extent = 16'($urandom_range(1, 48));
      w.out_extent = 16'($urandom_range(1, 48));
      case ($urandom_range(0, 3))
         0: w.taps = 8'd1;
         1: w.taps = 8'd3;
         default: w.taps = 8'($urandom_range(1, 6));
      endcase
      w.step = 16'($urandom_range(1, 4));
      w.spread = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(2, 3)) : 16'd1;
      w.lead_pad = 16'($urandom_range(0, 5));
      w.pitch_bytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 256);
      if (roll < 6) begin
         w = {$urandom, $urandom, $urandom, 24'($urandom)};
      end else if (roll >= 92) begin
         w.in_extent = 16'($urandom_range(1, 65535));
         w.out_extent = 16'($urandom_range(1, 65535));
         w.taps = 8'($urandom_range(1, 255));
         w.step = 16'($urandom_range(1, 32767));
         w.spread = 16'($urandom_range(1, 32767));
         w.lead_pad = 16'($urandom_range(0, 32767));
      end else if (roll >= 80) begin
         case ($urandom_range(0, 6))
            0: w.in_extent = 16'd0;
            1: w.out_extent = 16'd0;
            2: w.taps = 8'd0;
            3: w.step = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'h8000 | 16'($urandom);
            4: w.spread = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'h8000 | 16'($urandom);
            5: w.lead_pad = 16'h8000 | 16'($urandom);
            default: w.pitch_bytes = 32'd0;
         endcase
      end
      return w;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = val;
      case (idx)
         CsrSpatialRank: cfg_rank = val[1:0];
         CsrBatchCount: cfg_batch = val[15:0];
         CsrChannelTotal: cfg_total = val[15:0];
         CsrChannelsInGrp: cfg_group = val[15:0];
         CsrChannelPitch: cfg_pitch = val[15:0];
         CsrSpanBytes: cfg_span = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (awaited_axes.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // Called at a falling edge; returns at the falling edge after the handshake.
   task automatic send_word(input req_word_type w, input bit typed,
                            input plan_result_type want);
      plan_result_type predicted;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = w;
      do @(posedge clock); while (!req_tready);
      predicted = plan_axis(w);
      awaited_axes.push_back(typed ? want : predicted);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic random_setup();
      logic [15:0] batch, total, group, pitch;
      logic [31:0] span;
      logic [1:0] rank;
      int pick;
      pick = $urandom_range(0, 99);
      rank = (pick < 8) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(1, 2));
      total = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 64));
      group = 16'($urandom_range(1, total));
      batch = 16'($urandom_range(1, 65535));
      pitch = 16'd1;
      span = $urandom_range(1, 32'hFFFF_FFFF);
      if (pick >= 8 && pick < 22) begin
         case ($urandom_range(0, 5))
            0: batch = 16'd0;
            1: total = 16'd0;
            2: group = 16'd0;
            3: begin
               total = 16'($urandom_range(1, 64));
               group = total + 16'd1;
            end
            4: pitch = 16'($urandom_range(2, 65535));
            default: span = 32'd0;
         endcase
      end
      write_reg(CsrSpatialRank, {30'($urandom), rank});
      write_reg(CsrBatchCount, {16'($urandom), batch});
      write_reg(CsrChannelTotal, {16'($urandom), total});
      write_reg(CsrChannelsInGrp, {16'($urandom), group});
      write_reg(CsrChannelPitch, {16'($urandom), pitch});
      write_reg(CsrSpanBytes, span);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_axes.size() == 0) begin
            $error("response word arrived with nothing expected");
            mismatch_count++;
         end else begin
            plan_result_type want;
            want = awaited_axes.pop_front();
            check_field("axis_no", 64'(want.axis_no), 64'(rsp_tuser));
            check_field("first_inside", 64'(want.first_inside), 64'(rsp_view.first_inside));
            check_field("past_inside", 64'(want.past_inside), 64'(rsp_view.past_inside));
            check_field("out_step_bytes", 64'(want.out_step_bytes),
                        64'(rsp_view.out_step_bytes));
            check_field("tap_step_bytes", 64'(want.tap_step_bytes),
                        64'(rsp_view.tap_step_bytes));
            check_field("plan_done", 64'(want.plan_done), 64'(rsp_tlast));
            check_field("plan_status", 64'(want.plan_status), 64'(rsp_view.plan_status));
            check_field("out_points", 64'(want.out_points), 64'(rsp_view.out_points));
            check_field("tap_points", 64'(want.tap_points), 64'(rsp_view.tap_points));
            check_field("kernel_path", 64'(want.kernel_path), 64'(rsp_view.kernel_path));
            words_checked++;
         end
      end
   end

   initial begin
      int phase, k;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      cfg_rank = 2'd1;
      cfg_batch = 16'd1;
      cfg_total = 16'd1;
      cfg_group = 16'd1;
      cfg_pitch = 16'd1;
      cfg_span = 32'd1;
      forget_plan();
      dir_tab = '{
         fixed_row(word_row(16'd8, 16'd8, 8'd1, 16'd1, 16'd1, 16'd0, 32'd4),
                   unit_axis(StatusOk, PathOneByOne)),
         fixed_row(word_row(16'd8, 16'd5, 8'd3, 16'd0, 16'd1, 16'd0, 32'd1),
                   bad_axis(32'd5, 16'd3)),
         fixed_row(word_row(16'd8, 16'd5, 8'd3, 16'd1, 16'hFFFF, 16'd0, 32'd1),
                   bad_axis(32'd5, 16'd3)),
         fixed_row(word_row(16'd8, 16'd5, 8'd3, 16'd1, 16'd1, 16'h8000, 32'd1),
                   bad_axis(32'd5, 16'd3)),
         fixed_row(word_row(16'd0, 16'd5, 8'd3, 16'd1, 16'd1, 16'd0, 32'd1),
                   bad_axis(32'd5, 16'd3)),
         fixed_row(word_row(16'd8, 16'd0, 8'd3, 16'd1, 16'd1, 16'd0, 32'd1),
                   bad_axis(32'd0, 16'd3)),
         fixed_row(word_row(16'd8, 16'd5, 8'd0, 16'd1, 16'd1, 16'd0, 32'd1),
                   bad_axis(32'd5, 16'd0)),
         fixed_row(word_row(16'd8, 16'd5, 8'd3, 16'd1, 16'd1, 16'd0, 32'd0),
                   bad_axis(32'd5, 16'd3)),
         fixed_row(word_row(16'd100, 16'd100, 8'd17, 16'd1, 16'd1, 16'd0, 32'd1),
                   '{1'b0, 16'd0, 16'd84, 47'd1, 47'd1, 1'b1, StatusUnsupported,
                     32'd100, 16'd17, PathGeneric}),
         word_row(16'hFFFF, 16'hFFFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF),
         word_row(16'd10, 16'd10, 8'd3, 16'd1, 16'd1, 16'd1, 32'd1),
         word_row(16'd10, 16'd4, 8'd3, 16'd2, 16'd2, 16'd5, 32'd1),
         reg_row(CsrSpatialRank, 32'd2),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd0, 32'd1),
         word_row(16'd16, 16'd16, 8'd5, 16'd1, 16'd1, 16'd0, 32'd1),
         reg_row(CsrChannelPitch, 32'd2),
         word_row(16'd8, 16'd5, 8'd3, 16'd0, 16'd1, 16'd0, 32'd1),
         word_row(16'd8, 16'd5, 8'd3, 16'd1, 16'd1, 16'd0, 32'd1),
         reg_row(CsrSpanBytes, 32'd0),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         reg_row(CsrSpanBytes, 32'hFFFF_FFFF),
         reg_row(CsrChannelPitch, 32'd1),
         reg_row(CsrChannelTotal, 32'd4),
         reg_row(CsrChannelsInGrp, 32'd5),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         word_row(16'd16, 16'd16, 8'd3, 16'd1, 16'd1, 16'd1, 32'd8),
         reg_row(CsrSpatialRank, 32'd3),
         fixed_row(word_row(16'd8, 16'd8, 8'd1, 16'd1, 16'd1, 16'd0, 32'd4),
                   unit_axis(StatusInvalid, PathGeneric)),
         reg_row(CsrSpatialRank, 32'd0),
         fixed_row(word_row(16'd8, 16'd8, 8'd1, 16'd1, 16'd1, 16'd0, 32'd4),
                   unit_axis(StatusInvalid, PathGeneric)),
         reg_row(CsrSpatialRank, 32'd1),
         reg_row(CsrChannelTotal, 32'hFFFF),
         reg_row(CsrChannelsInGrp, 32'hFFFF),
         reg_row(CsrBatchCount, 32'hFFFF),
         fixed_row(word_row(16'd8, 16'd8, 8'd1, 16'd1, 16'd1, 16'd0, 32'd4),
                   unit_axis(StatusOk, PathOneByOne)),
         reg_row(CsrBatchCount, 32'd0),
         fixed_row(word_row(16'd8, 16'd8, 8'd1, 16'd1, 16'd1, 16'd0, 32'd4),
                   unit_axis(StatusInvalid, PathGeneric))
      };
      repeat (4) @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == RowReg) begin
            drain();
            write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
         end else begin
            send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].want);
         end
      end

      for (phase = 0; phase < 14; phase++) begin
         drain();
         setups++;
         if (phase == 1) begin
            write_reg(CsrSpatialRank, 32'd2);
            write_reg(CsrBatchCount, 32'hFFFF);
            write_reg(CsrChannelTotal, 32'hFFFF);
            write_reg(CsrChannelsInGrp, 32'hFFFF);
            write_reg(CsrChannelPitch, 32'd1);
            write_reg(CsrSpanBytes, 32'hFFFF_FFFF);
         end else begin
            random_setup();
         end
         idle_on = (phase < 12);
         for (k = 0; k < 73; k++) begin
            if (phase == 2 && k == 5) hold_asks++;
            if (phase == 3 && k == 30) begin
               req_tvalid = 1'b0;
               do @(negedge clock); while (awaited_axes.size() != 0);
            end
            send_word(random_axis(), 1'b0, '0);
         end
      end

      req_tvalid = 1'b0;
      while (awaited_axes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Sent %0d request words over %0d random setups plus the directed table.",
               words_sent, setups);
      $display("Plans: %0d ok (%0d one-by-one, %0d three-by-three), %0d invalid,",
               plans_ok, paths_one, paths_three, plans_invalid);
      $display("%0d unsupported; %0d words checked.", plans_unsupported, words_checked);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
